FILE: src/dpa_pkg.sv
// Shared types and codes for the delta patch apply block.
// Used by every module of the block but dpa_old_store; no dependencies of its own.
package dpa_pkg;

  localparam int unsigned OLD_DEPTH_DEF  = 65536;
  localparam longint unsigned MAX_STREAM_DEF = 64'd16777216;

  localparam int OLD_LEN_W = 17;
  localparam int LEN_W     = 25;
  localparam int SEEK_W    = 32;
  localparam int POS_W     = 33;
  localparam int CFG_W     = 25;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_CTRL   = 2'd1,
    CMD_DATA   = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_OLD_LENGTH   = 2'd0,
    CFG_NEW_LENGTH   = 2'd1,
    CFG_DIFF_LENGTH  = 2'd2,
    CFG_EXTRA_LENGTH = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_OVERFLOW   = 3'd1,
    ST_UNDERFLOW  = 3'd2,
    ST_FINISHED   = 3'd3,
    ST_UNEXPECTED = 3'd4
  } status_t;

  // Decision for one transaction, handed to the output stage
  typedef struct packed {
    logic       out_valid;
    logic       in_range;
    status_t    status;
    logic [7:0] data_byte;
  } dpa_res_t;

  localparam logic signed [POS_W:0] POS_MAX = 34'sd4294967295;
  localparam logic signed [POS_W:0] POS_MIN = -34'sd4294967296;

  // Add a signed step to the old position, clamped to the 33-bit range
  function automatic logic signed [POS_W-1:0] pos_move(
      input logic signed [POS_W-1:0]  pos,
      input logic signed [SEEK_W-1:0] delta);
    logic signed [POS_W:0] sum;
    sum = {pos[POS_W-1], pos} + {{2{delta[SEEK_W-1]}}, delta};
    if (sum > POS_MAX) begin
      sum = POS_MAX;
    end else if (sum < POS_MIN) begin
      sum = POS_MIN;
    end
    return sum[POS_W-1:0];
  endfunction

endpackage

FILE: src/dpa_old_store.sv
// Old data store: single-port-write, single-port-read RAM, registered read.
// Depends on nothing; depth comes from the top level.
module dpa_old_store #(
  parameter int unsigned DEPTH = 65536,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/dpa_ctrl.sv
// Patch sequencer: configuration registers, stream counters and old position.
// Uses dpa_pkg; drives the old store ports and the per-transaction decision.
module dpa_ctrl #(
  parameter int unsigned OLD_DEPTH = dpa_pkg::OLD_DEPTH_DEF,
  parameter longint unsigned MAX_STREAM = dpa_pkg::MAX_STREAM_DEF,
  parameter int AW = $clog2(OLD_DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [dpa_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         acc,
  input  logic [1:0]                   cmd,
  input  logic [7:0]                   data_byte,
  input  logic [dpa_pkg::LEN_W-1:0]    add_len,
  input  logic [dpa_pkg::LEN_W-1:0]    copy_len,
  input  logic [dpa_pkg::SEEK_W-1:0]   seek,
  output logic                         mem_we,
  output logic [AW-1:0]                mem_waddr,
  output logic [7:0]                   mem_wdata,
  output logic                         mem_re,
  output logic [AW-1:0]                mem_raddr,
  output dpa_pkg::dpa_res_t            res
);
  import dpa_pkg::*;

  localparam logic [LEN_W-1:0]  OldDepthW  = LEN_W'(OLD_DEPTH);
  localparam logic [POS_W:0]    MaxStreamW = (POS_W+1)'(MAX_STREAM);

  function automatic logic [LEN_W-1:0] stream_cap(input logic [LEN_W-1:0] v);
    return ({{(POS_W+1-LEN_W){1'b0}}, v} > MaxStreamW) ? LEN_W'(MAX_STREAM) : v;
  endfunction

  logic [OLD_LEN_W-1:0] old_length;
  logic [LEN_W-1:0]     new_length, diff_length, extra_length;

  logic [OLD_LEN_W-1:0]    load_pointer, load_pointer_next;
  logic [LEN_W-1:0]        new_position, new_position_next;
  logic signed [POS_W-1:0] old_position, old_position_next;
  logic [LEN_W-1:0]        diff_consumed, diff_consumed_next;
  logic [LEN_W-1:0]        extra_consumed, extra_consumed_next;
  logic [LEN_W-1:0]        add_remaining, add_remaining_next;
  logic [LEN_W-1:0]        copy_remaining, copy_remaining_next;
  logic signed [SEEK_W-1:0] pending_seek, pending_seek_next;
  logic                    error_flag, error_flag_next;

  logic [OLD_LEN_W-1:0] old_cap;
  logic [LEN_W-1:0]     nl, dl, el;
  logic [LEN_W+1:0]     end_add, end_all, diff_end, extra_end;
  logic                 in_range, busy;
  logic signed [POS_W-1:0] pos_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      old_length   <= '0;
      new_length   <= '0;
      diff_length  <= '0;
      extra_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_OLD_LENGTH:   old_length   <= cfg_data[OLD_LEN_W-1:0];
        CFG_NEW_LENGTH:   new_length   <= cfg_data;
        CFG_DIFF_LENGTH:  diff_length  <= cfg_data;
        CFG_EXTRA_LENGTH: extra_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    old_cap = ({{(LEN_W-OLD_LEN_W){1'b0}}, old_length} > OldDepthW)
            ? OLD_LEN_W'(OLD_DEPTH) : old_length;
    nl = stream_cap(new_length);
    dl = stream_cap(diff_length);
    el = stream_cap(extra_length);
    end_add   = {2'b0, new_position} + {2'b0, add_len};
    end_all   = end_add + {2'b0, copy_len};
    diff_end  = {2'b0, diff_consumed} + {2'b0, add_len};
    extra_end = {2'b0, extra_consumed} + {2'b0, copy_len};
    in_range  = !old_position[POS_W-1]
              && (old_position[POS_W-2:0] < {{(POS_W-1-OLD_LEN_W){1'b0}}, old_cap});
    busy      = (add_remaining != '0) || (copy_remaining != '0);
    pos_step  = pos_move(old_position, 32'sd1);
  end

  always_comb begin
    load_pointer_next   = load_pointer;
    new_position_next   = new_position;
    old_position_next   = old_position;
    diff_consumed_next  = diff_consumed;
    extra_consumed_next = extra_consumed;
    add_remaining_next  = add_remaining;
    copy_remaining_next = copy_remaining;
    pending_seek_next   = pending_seek;
    error_flag_next     = error_flag;
    mem_we    = 1'b0;
    res       = '{out_valid: 1'b0, in_range: 1'b0, status: ST_OK, data_byte: 8'd0};

    unique case (cmd_t'(cmd))
      CMD_LOAD: begin
        if (load_pointer >= old_cap) begin
          res.status = ST_UNEXPECTED;
        end else begin
          mem_we            = acc;
          load_pointer_next = load_pointer + 1'b1;
        end
      end
      CMD_CTRL: begin
        if (error_flag) begin
          res.status = ST_OVERFLOW;
        end else if (busy) begin
          res.status = ST_UNEXPECTED;
        end else if ((end_add > {2'b0, nl}) || (end_all > {2'b0, nl})
                     || (diff_end > {2'b0, dl}) || (extra_end > {2'b0, el})) begin
          error_flag_next = 1'b1;
          res.status      = ST_OVERFLOW;
        end else begin
          diff_consumed_next  = diff_end[LEN_W-1:0];
          extra_consumed_next = extra_end[LEN_W-1:0];
          add_remaining_next  = add_len;
          copy_remaining_next = copy_len;
          pending_seek_next   = seek;
          if ((add_len == '0) && (copy_len == '0)) begin
            old_position_next = pos_move(old_position, seek);
          end
        end
      end
      CMD_DATA: begin
        if (error_flag) begin
          res.status = ST_OVERFLOW;
        end else if (add_remaining != '0) begin
          res.out_valid      = 1'b1;
          res.in_range       = in_range;
          res.data_byte      = data_byte;
          add_remaining_next = add_remaining - 1'b1;
          new_position_next  = new_position + 1'b1;
          // Last add byte with no copy part: seek follows the step at once
          if ((add_remaining == LEN_W'(1)) && (copy_remaining == '0)) begin
            old_position_next = pos_move(pos_step, pending_seek);
          end else begin
            old_position_next = pos_step;
          end
        end else if (copy_remaining != '0) begin
          res.out_valid       = 1'b1;
          res.data_byte       = data_byte;
          copy_remaining_next = copy_remaining - 1'b1;
          new_position_next   = new_position + 1'b1;
          if (copy_remaining == LEN_W'(1)) begin
            old_position_next = pos_move(old_position, pending_seek);
          end
        end else begin
          res.status = ST_UNEXPECTED;
        end
      end
      CMD_FINISH: begin
        if (error_flag) begin
          res.status = ST_OVERFLOW;
        end else if (busy || (new_position != nl) || (diff_consumed != dl)
                     || (extra_consumed != el)) begin
          error_flag_next = 1'b1;
          res.status      = ST_UNDERFLOW;
        end else begin
          res.status = ST_FINISHED;
        end
      end
      default: ;
    endcase
  end

  assign mem_waddr = AW'(load_pointer);
  assign mem_wdata = data_byte;
  assign mem_re    = acc;
  assign mem_raddr = AW'(old_position[POS_W-2:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pointer   <= '0;
      new_position   <= '0;
      old_position   <= '0;
      diff_consumed  <= '0;
      extra_consumed <= '0;
      add_remaining  <= '0;
      copy_remaining <= '0;
      pending_seek   <= '0;
      error_flag     <= 1'b0;
    end else if (acc) begin
      load_pointer   <= load_pointer_next;
      new_position   <= new_position_next;
      old_position   <= old_position_next;
      diff_consumed  <= diff_consumed_next;
      extra_consumed <= extra_consumed_next;
      add_remaining  <= add_remaining_next;
      copy_remaining <= copy_remaining_next;
      pending_seek   <= pending_seek_next;
      error_flag     <= error_flag_next;
    end
  end

endmodule

FILE: src/dpa_out_stage.sv
// Output register: holds one decision beside the store read data.
// Uses dpa_pkg; sits between dpa_ctrl/dpa_old_store and the master side.
module dpa_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  dpa_pkg::dpa_res_t res_in,
  input  logic [7:0]        rdata,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [15:0]       m_tdata,
  output logic              m_tuser,
  output logic              take
);
  import dpa_pkg::*;

  dpa_res_t   held;
  logic [7:0] sum;

  // Store read data lands with the held decision, both change only on load
  assign take = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res_in;
    end
  end

  assign sum     = held.data_byte + (held.in_range ? rdata : 8'd0);
  assign m_tdata = {5'd0, held.status, sum};
  assign m_tuser = held.out_valid;

endmodule

FILE: src/delta_patch_apply.sv
// Delta patch apply block: top level.
// Depends on dpa_pkg, dpa_ctrl, dpa_old_store and dpa_out_stage.
//
// Usage: write old_length, new_length, diff_length and extra_length on the
// configuration port (cfg_index 0..3) while idle. Then send transactions on
// the slave side, kind in s_tuser: load old bytes in order, then control
// triples each followed by their add and copy data bytes, then a finish.
// Every transaction returns exactly one result on the master side: a
// reconstructed byte with m_tuser high, or a status with m_tuser low.
// m_tvalid rises in the cycle after acceptance. Throughput is one
// transaction per cycle while m_tready is high: the add path issues one
// old store read per transaction and the sum is taken from the registered
// read data. Old bytes are written one per load transaction; no pass over
// the store. Reset clears all counters, the error flag, the configuration
// and the output valid flag; store contents stay undefined until loaded.
// When the receiver holds m_tready low the result stays on the master side
// and s_tready drops; one result is buffered, none is lost.
module delta_patch_apply #(
  parameter int unsigned OLD_DEPTH = dpa_pkg::OLD_DEPTH_DEF,
  parameter longint unsigned MAX_STREAM = dpa_pkg::MAX_STREAM_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [dpa_pkg::CFG_W-1:0] cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // data_byte[7:0], add_len[32:8], copy_len[57:33], seek[89:58], zero fill
  input  logic [95:0]               s_tdata,
  // cmd[1:0]
  input  logic [1:0]                s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // out_byte[7:0], status[10:8], zero fill
  output logic [15:0]               m_tdata,
  // out_valid[0]
  output logic                      m_tuser
);
  import dpa_pkg::*;

  localparam int AW = $clog2(OLD_DEPTH);

  logic          acc;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;
  dpa_res_t      res;

  assign acc = s_tvalid && s_tready;

  dpa_ctrl #(
    .OLD_DEPTH (OLD_DEPTH),
    .MAX_STREAM(MAX_STREAM),
    .AW        (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .cmd       (s_tuser),
    .data_byte (s_tdata[7:0]),
    .add_len   (s_tdata[32:8]),
    .copy_len  (s_tdata[57:33]),
    .seek      (s_tdata[89:58]),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .res       (res)
  );

  dpa_old_store #(
    .DEPTH(OLD_DEPTH),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  dpa_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (acc),
    .res_in  (res),
    .rdata   (mem_rdata),
    .m_tready(m_tready),
    .m_tvalid(m_tvalid),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .take    (s_tready)
  );

endmodule

FILE: src/dpa_checker.sv
// Port-level checks for delta_patch_apply, attached by the bind below.
// Uses dpa_pkg status codes; sees only the top-level ports.
module dpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);
  import dpa_pkg::*;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Every accepted transaction gives a result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted transaction gave no result");

  // A pending result blocks input only while the receiver stalls
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid || m_tready |-> s_tready)
    else $error("input stalled with output free");

  // Output bytes carry status ok
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[10:8] == ST_OK)
    else $error("output byte with error status");

  // Status-only results carry a zero byte
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
    else $error("status result with nonzero byte");

endmodule

bind delta_patch_apply dpa_checker u_dpa_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

FILE: bench/tb_delta_patch_apply.sv
`timescale 1ns / 100ps
// Self-checking bench for delta_patch_apply: loads old bytes, runs control
// triples with their patch bytes and finish checks, predicts every result.
// Depends on dpa_pkg and the delta_patch_apply RTL.
module tb_delta_patch_apply;
  import dpa_pkg::*;

  localparam int unsigned STORE_DEPTH = 65536;
  localparam int unsigned FILL_LEN = 64;
  localparam longint STREAM_CAP = 64'sd16777216;
  localparam longint OLD_POS_MAX = 64'sd4294967295;
  localparam longint OLD_POS_MIN = -64'sd4294967296;
  localparam logic [24:0] LEN_MAX = 25'h1FFFFFF;
  localparam logic signed [31:0] SEEK_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] SEEK_MIN = 32'sh80000000;

  typedef struct {
    logic [7:0] out_byte;
    logic       out_valid;
    status_t    status;
  } patch_res_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              s_tvalid;
  logic              s_tready;
  logic [95:0]       s_tdata;
  logic [1:0]        s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [15:0]       m_tdata;
  logic              m_tuser;

  // Shadow of the block: configuration and patch progress
  logic [7:0]        old_mem [STORE_DEPTH];
  logic [16:0]       reg_old_len;
  logic [24:0]       reg_new_len, reg_diff_len, reg_extra_len;
  logic [16:0]       load_ptr;
  logic [24:0]       new_pos, diff_used, extra_used, add_left, copy_left;
  logic signed [32:0] old_pos;
  logic signed [31:0] seek_hold;
  logic              err_sticky;

  patch_res_t        result_q[$];
  int                n_items, n_bytes, n_checked, n_fail;
  bit                idling;
  bit                ended_in_overflow;

  delta_patch_apply i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("delta_patch_apply: mismatch");
    $finish;
  end

  function automatic longint old_span();
    longint v;
    v = reg_old_len;
    return (v > STORE_DEPTH) ? STORE_DEPTH : v;
  endfunction

  function automatic longint stream_lim(logic [24:0] v);
    longint w;
    w = v;
    return (w > STREAM_CAP) ? STREAM_CAP : w;
  endfunction

  // Move the old position, clamped to the 33-bit signed range
  function automatic void shift_old(longint delta);
    longint p;
    p = longint'(old_pos) + delta;
    if (p > OLD_POS_MAX) p = OLD_POS_MAX;
    else if (p < OLD_POS_MIN) p = OLD_POS_MIN;
    old_pos = p[32:0];
  endfunction

  function automatic patch_res_t predict_item(cmd_t cmd, logic [7:0] dbyte,
      logic [24:0] add_len, logic [24:0] copy_len, logic signed [31:0] seek);
    patch_res_t r;
    logic [7:0] v;
    r.out_byte  = 8'h00;
    r.out_valid = 1'b0;
    r.status    = ST_OK;
    if (cmd == CMD_LOAD) begin
      if (load_ptr >= old_span()) begin
        r.status = ST_UNEXPECTED;
      end else begin
        old_mem[load_ptr[15:0]] = dbyte;
        load_ptr++;
      end
    end else if (err_sticky) begin
      r.status = ST_OVERFLOW;
    end else begin
      case (cmd)
        CMD_CTRL: begin
          if (add_left != 0 || copy_left != 0) begin
            r.status = ST_UNEXPECTED;
          end else if (longint'(new_pos) + add_len + copy_len > stream_lim(reg_new_len) ||
                       longint'(diff_used) + add_len > stream_lim(reg_diff_len) ||
                       longint'(extra_used) + copy_len > stream_lim(reg_extra_len)) begin
            err_sticky = 1'b1;
            r.status   = ST_OVERFLOW;
          end else begin
            diff_used  += add_len;
            extra_used += copy_len;
            add_left   = add_len;
            copy_left  = copy_len;
            seek_hold  = seek;
            if (add_len == 0 && copy_len == 0) shift_old(seek_hold);
          end
        end
        CMD_DATA: begin
          if (add_left != 0) begin
            v = dbyte;
            if (old_pos >= 0 && longint'(old_pos) < old_span()) begin
              v = dbyte + old_mem[old_pos[15:0]];
            end
            add_left--;
            shift_old(1);
            new_pos++;
            if (add_left == 0 && copy_left == 0) shift_old(seek_hold);
            r.out_byte  = v;
            r.out_valid = 1'b1;
          end else if (copy_left != 0) begin
            copy_left--;
            new_pos++;
            if (copy_left == 0) shift_old(seek_hold);
            r.out_byte  = dbyte;
            r.out_valid = 1'b1;
          end else begin
            r.status = ST_UNEXPECTED;
          end
        end
        default: begin
          if (add_left != 0 || copy_left != 0 ||
              new_pos != stream_lim(reg_new_len) ||
              diff_used != stream_lim(reg_diff_len) ||
              extra_used != stream_lim(reg_extra_len)) begin
            err_sticky = 1'b1;
            r.status   = ST_UNDERFLOW;
          end else begin
            r.status = ST_FINISHED;
          end
        end
      endcase
    end
    if (r.out_valid) n_bytes++;
    return r;
  endfunction

  function automatic logic [24:0] rand_len();
    logic [31:0] r;
    r = $urandom;
    return r[24:0];
  endfunction

  // Seek that lands the old position on target after advance add bytes
  function automatic logic signed [31:0] seek_to(longint target, longint advance);
    longint step;
    step = target - longint'(old_pos) - advance;
    if (step > longint'(SEEK_MAX)) step = SEEK_MAX;
    else if (step < longint'(SEEK_MIN)) step = SEEK_MIN;
    return step[31:0];
  endfunction

  task automatic send_item(cmd_t cmd, logic [7:0] dbyte, logic [24:0] add_len,
      logic [24:0] copy_len, logic signed [31:0] seek);
    if (idling && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'd0, seek, copy_len, add_len, dbyte};
    do @(posedge clk); while (!s_tready);
    result_q.push_back(predict_item(cmd, dbyte, add_len, copy_len, seek));
    n_items++;
  endtask

  task automatic send_load(logic [7:0] value);
    send_item(CMD_LOAD, value, rand_len(), rand_len(), $urandom);
  endtask

  task automatic send_ctrl(logic [24:0] add_len, logic [24:0] copy_len,
      logic signed [31:0] seek);
    send_item(CMD_CTRL, 8'($urandom_range(0, 255)), add_len, copy_len, seek);
  endtask

  task automatic send_data(logic [7:0] value);
    send_item(CMD_DATA, value, rand_len(), rand_len(), $urandom);
  endtask

  task automatic send_finish();
    send_item(CMD_FINISH, 8'($urandom_range(0, 255)), rand_len(), rand_len(), $urandom);
  endtask

  // Hold the sender until every pending result is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      CFG_OLD_LENGTH:  reg_old_len   = value[16:0];
      CFG_NEW_LENGTH:  reg_new_len   = value[24:0];
      CFG_DIFF_LENGTH: reg_diff_len  = value[24:0];
      default:         reg_extra_len = value[24:0];
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Registers still at reset: nothing to load, nothing to patch
  task automatic test_empty_stream();
    send_finish();
    send_data(8'hA5);
    send_load(8'h5A);
    send_ctrl(25'd0, 25'd0, -32'sd1);
  endtask

  task automatic test_directed_patch();
    drain_results();
    write_reg(CFG_OLD_LENGTH, 25'd3);
    write_reg(CFG_NEW_LENGTH, 25'd8);
    write_reg(CFG_DIFF_LENGTH, 25'd6);
    write_reg(CFG_EXTRA_LENGTH, 25'd2);
    send_load(8'hFF);
    send_load(8'h01);
    send_load(8'h80);
    send_load(8'h00);
    // first add byte sits one before the old data, second wraps the sum
    send_ctrl(25'd3, 25'd2, SEEK_MIN);
    send_data(8'hFF);
    send_data(8'hFF);
    send_ctrl(LEN_MAX, LEN_MAX, SEEK_MAX);
    send_data(8'h00);
    send_data(8'h00);
    send_data(8'hFF);
    send_ctrl(25'd0, 25'd0, SEEK_MAX);
    // adds run across the end of the old data
    send_ctrl(25'd3, 25'd0, -32'sd2);
    send_data(8'h7F);
    send_data(8'h80);
    send_data(8'h33);
    send_data(8'h12);
    send_finish();
  endtask

  task automatic test_position_limits();
    repeat (3) send_ctrl(25'd0, 25'd0, SEEK_MAX);
    repeat (4) send_ctrl(25'd0, 25'd0, SEEK_MIN);
    while (old_pos != 0) send_ctrl(25'd0, 25'd0, seek_to(0, 0));
  endtask

  task automatic test_store_fill();
    drain_results();
    // length above the store depth: loads run against the capped length
    write_reg(CFG_OLD_LENGTH, 25'h1FFFF);
    repeat (40) send_load(8'($urandom_range(0, 255)));
    drain_results();
    write_reg(CFG_OLD_LENGTH, 25'(FILL_LEN));
    while (load_ptr < FILL_LEN) send_load(8'($urandom_range(0, 255)));
    send_load(8'($urandom_range(0, 255)));
  endtask

  task automatic test_random_patches();
    int useful, n_ctl, k, j;
    int add_plan[6], copy_plan[6];
    int add_sum, copy_sum;
    longint span, target;
    logic signed [31:0] seek;
    useful = 0;
    while (useful < 480) begin
      idling = (useful >= 340) ? 1'b0 : ($urandom_range(0, 3) != 0);
      drain_results();
      // keep the old length within the loaded part of the store
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: write_reg(CFG_OLD_LENGTH, 25'd0);
          1: write_reg(CFG_OLD_LENGTH, 25'(load_ptr));
          default: write_reg(CFG_OLD_LENGTH, 25'($urandom_range(1, load_ptr)));
        endcase
      end
      n_ctl = $urandom_range(1, 6);
      add_sum = 0;
      copy_sum = 0;
      for (k = 0; k < n_ctl; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          add_plan[k] = 0;
          copy_plan[k] = 0;
        end else begin
          add_plan[k] = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 12);
          copy_plan[k] = $urandom_range(0, 12);
        end
        add_sum += add_plan[k];
        copy_sum += copy_plan[k];
      end
      write_reg(CFG_NEW_LENGTH, 25'(new_pos + add_sum + copy_sum));
      write_reg(CFG_DIFF_LENGTH, 25'(diff_used + add_sum));
      write_reg(CFG_EXTRA_LENGTH, 25'(extra_used + copy_sum));
      for (k = 0; k < n_ctl; k++) begin
        span = old_span();
        case ($urandom_range(0, 5))
          0, 1: target = (span > 0) ? $urandom_range(0, 32'(span - 1)) : 0;
          2: target = longint'($urandom_range(0, 5)) - 3;
          3: target = span + longint'($urandom_range(0, 5)) - 3;
          default: target = OLD_POS_MAX;
        endcase
        // a wild seek throws the position far out; later ones steer back
        seek = (target == OLD_POS_MAX) ? $urandom : seek_to(target, add_plan[k]);
        send_ctrl(25'(add_plan[k]), 25'(copy_plan[k]), seek);
        useful++;
        for (j = 0; j < add_plan[k] + copy_plan[k]; j++) begin
          if ($urandom_range(0, 19) == 0) send_ctrl(rand_len(), rand_len(), $urandom);
          if ($urandom_range(0, 24) == 0) send_load(8'($urandom_range(0, 255)));
          send_data(8'($urandom_range(0, 255)));
          useful++;
        end
        if ($urandom_range(0, 5) == 0) send_data(8'($urandom_range(0, 255)));
      end
      send_finish();
      useful++;
      if ($urandom_range(0, 7) == 0) send_finish();
    end
  endtask

  // One sticky error per run: underflow or overflow, picked at random
  task automatic test_sticky_error();
    idling = 1'b0;
    drain_results();
    write_reg(CFG_NEW_LENGTH, LEN_MAX);
    write_reg(CFG_DIFF_LENGTH, LEN_MAX);
    write_reg(CFG_EXTRA_LENGTH, LEN_MAX);
    ended_in_overflow = 1'($urandom_range(0, 1));
    if (ended_in_overflow) begin
      send_ctrl(LEN_MAX, 25'd0, 32'sd0);
    end else begin
      send_finish();
    end
    send_ctrl(25'd1, 25'd1, 32'sd0);
    send_data(8'h5A);
    send_finish();
    send_load(8'hC3);
  endtask

  initial begin
    m_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (idling && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    patch_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_checked++;
      if (result_q.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected result, expected none, got byte %02h valid %0b status %0d",
                 $time, m_tdata[7:0], m_tuser, m_tdata[10:8]);
      end else begin
        want = result_q.pop_front();
        if (m_tdata[7:0] !== want.out_byte || m_tuser !== want.out_valid ||
            m_tdata[10:8] !== want.status) begin
          n_fail++;
          if (n_fail <= 25) begin
            $display("%0t: result %0d expected byte %02h valid %0b status %0d, got byte %02h valid %0b status %0d",
                     $time, n_checked, want.out_byte, want.out_valid, want.status,
                     m_tdata[7:0], m_tuser, m_tdata[10:8]);
          end
        end
      end
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = 2'd0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 2'd0;
    idling    = 1'b1;
    reg_old_len   = '0;
    reg_new_len   = '0;
    reg_diff_len  = '0;
    reg_extra_len = '0;
    load_ptr   = '0;
    new_pos    = '0;
    diff_used  = '0;
    extra_used = '0;
    add_left   = '0;
    copy_left  = '0;
    old_pos    = '0;
    seek_hold  = '0;
    err_sticky = 1'b0;
    n_items = 0;
    n_bytes = 0;
    n_checked = 0;
    n_fail = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_stream();
    test_directed_patch();
    test_position_limits();
    test_store_fill();
    test_random_patches();
    test_sticky_error();

    drain_results();
    repeat (8) @(posedge clk);
    $display("Run covered %0d transactions, %0d rebuilt bytes, %0d results compared.",
             n_items, n_bytes, n_checked);
    $display("Old store filled past a capped length, position limits hit, run closed by a sticky %s.",
             ended_in_overflow ? "overflow" : "underflow");
    if (n_fail == 0) begin
      $display("delta_patch_apply: match");
    end else begin
      $display("delta_patch_apply: mismatch");
    end
    $finish;
  end

endmodule
